>>> hdl/b64enc_pkg.sv
// Types, constants and the symbol-to-ASCII map shared by the base64 encoder.
// No dependencies; every other file of the block imports this package.
package b64enc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SymW  = 6;
  localparam int unsigned Slots = 4;

  localparam logic [ByteW-1:0] PadChar   = 8'h3D; // '='
  localparam logic [ByteW-1:0] CharUpA   = 8'h41; // 'A'
  localparam logic [ByteW-1:0] CharLowA  = 8'h61; // 'a'
  localparam logic [ByteW-1:0] CharZero  = 8'h30; // '0'
  localparam logic [ByteW-1:0] CharPlus  = 8'h2B; // '+'
  localparam logic [ByteW-1:0] CharSlash = 8'h2F; // '/'
  localparam logic [ByteW-1:0] CharDash  = 8'h2D; // '-'
  localparam logic [ByteW-1:0] CharUnder = 8'h5F; // '_'

  localparam logic [SymW-1:0] SymLowerBase = 6'd26;
  localparam logic [SymW-1:0] SymDigitBase = 6'd52;
  localparam logic [SymW-1:0] SymSpecial62 = 6'd62;

  // Position within the current 3-byte group
  typedef enum logic [2:0] {
    PH_0 = 3'b001,
    PH_1 = 3'b010,
    PH_2 = 3'b100
  } phase_e;

  // One output character: a 6-bit symbol or a pad
  typedef struct packed {
    logic            pad;
    logic [SymW-1:0] sym;
  } slot_t;

  // Everything one input byte produces
  typedef struct packed {
    slot_t [Slots-1:0] slots;
    logic [1:0]        last_idx; // index of the final slot used
    logic              eom;      // final slot closes the message
  } job_t;

  function automatic logic [ByteW-1:0] sym_char(input logic [SymW-1:0] v, input logic url);
    logic [ByteW-1:0] v8;
    logic [ByteW-1:0] c;
    v8 = {2'b00, v};
    if (v < SymLowerBase) begin
      c = CharUpA + v8;
    end else if (v < SymDigitBase) begin
      c = CharLowA + (v8 - {2'b00, SymLowerBase});
    end else if (v < SymSpecial62) begin
      c = CharZero + (v8 - {2'b00, SymDigitBase});
    end else if (v == SymSpecial62) begin
      c = url ? CharDash : CharPlus;
    end else begin
      c = url ? CharUnder : CharSlash;
    end
    return c;
  endfunction

endpackage

>>> hdl/base64_stream_encoder.sv
// Top level of the streaming base64 encoder (standard or URL-safe alphabet).
// Depends on b64enc_pkg, b64enc_front, b64enc_fifo and b64enc_back.
//
// Usage:
//   Slave stream: one message byte per transfer in s_axis_tdata, with
//   s_axis_tlast high on the final byte of a message.
//   Master stream: one ASCII character per transfer in m_axis_tdata, '='
//   padding included; m_axis_tlast marks the final character of a message.
//   cfg_we_i / cfg_wdata_i write the alphabet select (1 = URL-safe '-' '_');
//   write it only while no message is in flight.
// Path: with the queue and output idle, a transferred byte's job is written into
//   the job queue, then its first character is loaded into the output register.
// Throughput: the output register issues one character per cycle while
//   m_axis_tready is high; a byte produces 1, 1, 2 characters for the bytes of a
//   group, 2, 3 or 4 for a final byte. The input takes a byte every cycle while
//   the job queue (FIFO_DEPTH entries) has room.
// Reset: clears the group phase, leftover bits, queue and output valid, and
//   selects the standard alphabet.
// Stall: with m_axis_tready low the output character holds, the queue fills,
//   and s_axis_tready drops once the queue is full.
module base64_stream_encoder import b64enc_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,    // [0] url_alphabet
  // slave stream: raw bytes
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] data_byte
  input  logic             s_axis_tlast,   // end_of_message
  // master stream: encoded characters
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [ByteW-1:0] m_axis_tdata,   // [7:0] out_char
  output logic             m_axis_tlast    // last_char
);

  logic url_q;
  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t head_job;

  // Alphabet select; takes effect on characters issued after the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_q <= 1'b0;
    end else if (cfg_we_i) begin
      url_q <= cfg_wdata_i;
    end
  end

  b64enc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_eom_i   (s_axis_tlast),
    .q_full_i   (full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .job_o      (push_job)
  );

  b64enc_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .full_o     (full),
    .empty_o    (empty)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .url_i       (url_q),
    .head_i      (head_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> hdl/b64enc_front.sv
// Front end: accepts message bytes, tracks the group phase and leftover bits,
// and turns each byte into a job of up to four slots. Uses b64enc_pkg.
module b64enc_front import b64enc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_eom_i,
  input  logic             q_full_i,
  output logic             in_ready_o,
  output logic             push_o,
  output job_t             job_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    job_o          = '0;
    job_o.eom      = in_eom_i;
    phase_d        = phase_q;
    left_d         = left_q;
    case (phase_q)
      PH_1: begin
        job_o.slots[0].sym = {left_q[1:0], in_byte_i[7:4]};
        if (in_eom_i) begin
          job_o.slots[1].sym = {in_byte_i[3:0], 2'b00};
          job_o.slots[2].pad = 1'b1;
          job_o.last_idx     = 2'd2;
          phase_d            = PH_0;
          left_d             = '0;
        end else begin
          job_o.last_idx = 2'd0;
          phase_d        = PH_2;
          left_d         = in_byte_i[3:0];
        end
      end
      PH_2: begin
        job_o.slots[0].sym = {left_q, in_byte_i[7:6]};
        job_o.slots[1].sym = in_byte_i[5:0];
        job_o.last_idx     = 2'd1;
        phase_d            = PH_0;
        left_d             = '0;
      end
      default: begin
        // unknown codes act as the start of a group
        job_o.slots[0].sym = in_byte_i[7:2];
        if (in_eom_i) begin
          job_o.slots[1].sym = {in_byte_i[1:0], 4'b0000};
          job_o.slots[2].pad = 1'b1;
          job_o.slots[3].pad = 1'b1;
          job_o.last_idx     = 2'd3;
          phase_d            = PH_0;
          left_d             = '0;
        end else begin
          job_o.last_idx = 2'd0;
          phase_d        = PH_1;
          left_d         = {2'b00, in_byte_i[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_0;
      left_q  <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

  a_left_clear_at_group_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_0) |-> (left_q == '0))
    else $error("leftover bits not clear at group start");

endmodule

>>> hdl/b64enc_fifo.sv
// Short job queue between the front and back ends of the base64 encoder.
// Register-based circular buffer of job_t entries; uses b64enc_pkg.
module b64enc_fifo import b64enc_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into a full job queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from an empty job queue");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("job queue count beyond depth");

endmodule

>>> hdl/b64enc_back.sv
// Back end: drains queue jobs one character per cycle while out_ready_i allows, into a
// registered output stage, mapping symbols to ASCII. Uses b64enc_pkg.
module b64enc_back import b64enc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             url_i,
  input  job_t             head_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [ByteW-1:0] out_char_o,
  output logic             out_last_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] char_q, char_d;
  logic             last_q, last_d;
  logic             busy_q, busy_d;
  logic [1:0]       idx_q, idx_d;
  job_t             cur_q, cur_d;

  job_t       src;
  logic [1:0] idx;
  slot_t      slot;
  logic       have;
  logic       adv;

  always_comb begin
    src     = busy_q ? cur_q : head_i;
    idx     = busy_q ? idx_q : 2'd0;
    slot    = src.slots[idx];
    have    = busy_q || !empty_i;
    adv     = !valid_q || out_ready_i;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    busy_d  = busy_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    pop_o   = 1'b0;
    if (adv) begin
      valid_d = have;
      if (have) begin
        char_d = slot.pad ? PadChar : sym_char(slot.sym, url_i);
        last_d = src.eom && (idx == src.last_idx);
        pop_o  = !busy_q;
        cur_d  = src;
        if (idx == src.last_idx) begin
          busy_d = 1'b0;
          idx_d  = 2'd0;
        end else begin
          busy_d = 1'b1;
          idx_d  = idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      busy_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      busy_q  <= busy_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    cur_q  <= cur_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  a_busy_index_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q != 2'd0) && (idx_q <= cur_q.last_idx))
    else $error("slot index outside the current job");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_encoder: random and directed messages
// against a character predictor. Depends on b64enc_pkg and the encoder RTL only.

class b64_char_predictor;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } enc_char_t;

  logic        url;
  logic [1:0]  phase;
  logic [3:0]  carry;
  string       alphabet;
  enc_char_t   pending_chars[$];
  int unsigned errors;
  int unsigned chars_seen;
  int unsigned msgs_closed;

  function new();
    url         = 1'b0;
    phase       = 2'd0;
    carry       = 4'd0;
    alphabet    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
    errors      = 0;
    chars_seen  = 0;
    msgs_closed = 0;
  endfunction

  function logic [7:0] symbol_ascii(logic [5:0] s);
    if (s >= b64enc_pkg::SymSpecial62) begin
      if (s == b64enc_pkg::SymSpecial62) begin
        return url ? b64enc_pkg::CharDash : b64enc_pkg::CharPlus;
      end
      return url ? b64enc_pkg::CharUnder : b64enc_pkg::CharSlash;
    end
    return alphabet[s];
  endfunction

  function void add_char(logic [7:0] code, logic last);
    enc_char_t c;
    c.code = code;
    c.last = last;
    pending_chars.push_back(c);
  endfunction

  // Work out the characters one accepted byte produces and advance the group state.
  function void take_byte(logic [7:0] b, logic eom);
    case (phase)
      2'd1: begin
        add_char(symbol_ascii({carry[1:0], b[7:4]}), 1'b0);
        if (eom) begin
          add_char(symbol_ascii({b[3:0], 2'b00}), 1'b0);
          add_char(b64enc_pkg::PadChar, 1'b1);
        end else begin
          carry = b[3:0];
          phase = 2'd2;
        end
      end
      2'd2: begin
        add_char(symbol_ascii({carry, b[7:6]}), 1'b0);
        add_char(symbol_ascii(b[5:0]), eom);
        carry = 4'd0;
        phase = 2'd0;
      end
      default: begin
        add_char(symbol_ascii(b[7:2]), 1'b0);
        if (eom) begin
          add_char(symbol_ascii({b[1:0], 4'b0000}), 1'b0);
          add_char(b64enc_pkg::PadChar, 1'b0);
          add_char(b64enc_pkg::PadChar, 1'b1);
        end else begin
          carry = {2'b00, b[1:0]};
          phase = 2'd1;
        end
      end
    endcase
    if (eom) begin
      phase = 2'd0;
      carry = 4'd0;
    end
  endfunction

  function void check_char(logic [7:0] code, logic last);
    enc_char_t want;
    chars_seen++;
    if (last) msgs_closed++;
    if (pending_chars.size() == 0) begin
      errors++;
      $display("%0t: unexpected character: expected none, actual %h last %b",
               $time, code, last);
      return;
    end
    want = pending_chars.pop_front();
    if (want.code !== code) begin
      errors++;
      $display("%0t: out_char mismatch: expected %h, actual %h", $time, want.code, code);
    end
    if (want.last !== last) begin
      errors++;
      $display("%0t: last_char mismatch: expected %b, actual %b", $time, want.last, last);
    end
  endfunction

endclass

module tb;

  localparam int unsigned QUIET_LIMIT    = 2000; // cycles without any transfer
  localparam int unsigned HOLD_CYCLES    = 120;  // long receiver hold-off
  localparam int unsigned URL_SWITCH_AT  = 14;   // directed bytes sent with standard alphabet
  localparam int unsigned DIRECTED_COUNT = 20;
  localparam int unsigned RANDOM_PER_PASS = 105;
  localparam int unsigned BURST_LEN      = 24;

  // {end_of_message, data_byte}
  localparam logic [8:0] DIRECTED_SEQ [DIRECTED_COUNT] = '{
    9'h100,                         // one zero byte: two pads
    9'h1FF,                         // one 0xFF byte
    9'h0FF, 9'h1FF,                 // two bytes: one pad
    9'h0FB, 9'h0EF, 9'h1BE,         // symbol 62 four times
    9'h0FF, 9'h0FF, 9'h1FF,         // symbol 63 four times
    9'h04D, 9'h061, 9'h06E, 9'h100, // full group, then final byte opens a new group
    9'h0FB, 9'h0EF, 9'h1BE,         // URL-safe alphabet from here
    9'h0FF, 9'h1FF,
    9'h1F8
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  b64_char_predictor enc = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned bytes_sent;
  int unsigned alphabet_writes;
  int unsigned quiet_cycles;
  logic        hold_req;

  base64_stream_encoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Check every character transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      enc.check_char(m_axis_tdata, m_axis_tlast);
    end
  end

  // Abort when neither side has moved a transfer for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("** base64_stream_encoder: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random backpressure, plus a long hold-off when requested.
  initial begin : receiver
    int unsigned hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one byte, with random idle cycles ahead of it; hold until accepted.
  task automatic push_byte(input logic [7:0] b, input logic eom);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(255));
      s_axis_tlast  <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
    enc.take_byte(b, eom);
    bytes_sent++;
  endtask

  // Drop valid and wait until every expected character has come out.
  task automatic drain_output();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (enc.pending_chars.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_alphabet(input logic url_sel);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= url_sel;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    enc.url = url_sel;
    alphabet_writes++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      push_byte(pick_byte(), i == len - 1);
    end
  endtask

  // Random messages, mostly short so that every group phase ends a message often.
  task automatic run_random(input int unsigned count);
    int unsigned target;
    int unsigned len;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      len = ($urandom_range(5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 7);
      send_message(len);
      if ($urandom_range(11) == 0) drain_output();
    end
  endtask

  initial begin : stimulus
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'h00;
    s_axis_tlast    = 1'b0;
    hold_req        = 1'b0;
    quiet_cycles    = 0;
    bytes_sent      = 0;
    alphabet_writes = 0;
    tx_idle_pct     = 9;
    rx_idle_pct     = 82;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: pad cases, symbols 62 and 63 in both alphabets.
    write_alphabet(1'b0);
    for (int unsigned k = 0; k < URL_SWITCH_AT; k++) begin
      push_byte(DIRECTED_SEQ[k][7:0], DIRECTED_SEQ[k][8]);
    end
    drain_output();
    write_alphabet(1'b1);
    for (int unsigned k = URL_SWITCH_AT; k < DIRECTED_COUNT; k++) begin
      push_byte(DIRECTED_SEQ[k][7:0], DIRECTED_SEQ[k][8]);
    end
    drain_output();

    // Slow receiver.
    write_alphabet(1'($urandom_range(1)));
    run_random(RANDOM_PER_PASS);
    drain_output();

    // Slow sender.
    write_alphabet(1'b0);
    tx_idle_pct = 82;
    rx_idle_pct = 9;
    run_random(RANDOM_PER_PASS);
    drain_output();

    // Full rate; first a long receiver hold-off so the input side backs up.
    write_alphabet(1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    send_message(BURST_LEN);
    drain_output();
    run_random(RANDOM_PER_PASS - BURST_LEN);
    drain_output();
    repeat (8) @(posedge clk_i);

    if (enc.pending_chars.size() > 0) begin
      enc.errors += enc.pending_chars.size();
      $display("%0t: %0d expected characters never arrived", $time,
               enc.pending_chars.size());
    end
    $display("Encoded %0d bytes in %0d messages into %0d characters,", bytes_sent,
             enc.msgs_closed, enc.chars_seen);
    $display("with %0d alphabet writes across three backpressure profiles.",
             alphabet_writes);
    if (enc.errors == 0) begin
      $display("** base64_stream_encoder: PASSED **");
    end else begin
      $display("** base64_stream_encoder: FAILED **");
    end
    $finish;
  end

endmodule

>>> base64_stream_encoder.f
hdl/b64enc_pkg.sv
hdl/b64enc_front.sv
hdl/b64enc_fifo.sv
hdl/b64enc_back.sv
hdl/base64_stream_encoder.sv
tb/tb.sv
